// ===== hw/rtl/mpea_pkg.sv =====
// Shared types, codes and format helpers for the mixed-precision adder.
package mpea_pkg;

  typedef enum logic [2:0] {
    COMBO_F32      = 3'd0,
    COMBO_F16      = 3'd1,
    COMBO_F16_F16O = 3'd2,
    COMBO_F16_F32O = 3'd3,
    COMBO_BF16     = 3'd4,
    COMBO_BF_BFO   = 3'd5,
    COMBO_BF_F32O  = 3'd6,
    COMBO_UNUSED   = 3'd7
  } combo_t;

  typedef enum logic [1:0] {
    OUT_F32  = 2'd0,
    OUT_F16  = 2'd1,
    OUT_BF16 = 2'd2
  } out_fmt_t;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;

  // Aligned operands handed from the align stage to the add stage.
  typedef struct packed {
    logic        nan_res;
    logic [31:0] nan_val;
    logic        inv;
    logic        sub;
    logic        sign_l;
    logic [7:0]  exp_l;
    logic [26:0] mant_l;
    logic [26:0] mant_s;
    out_fmt_t    fmt;
  } align_t;

  // Raw sum handed from the add stage to the round stage.
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic [9:0]  exp;
    logic [27:0] mant;
    out_fmt_t    fmt;
  } sum_t;

  // Exact widening of a half-precision value to binary32.
  function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [10:0] mm;
    logic        found;
    logic [31:0] res;
    e = h[14:10];
    m = h[9:0];
    lz = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        lz = 4'(9 - i);
      end
    end
    mm = {1'b0, m} << (lz + 4'd1);
    if (e == 5'd31) begin
      res = {h[15], 8'hFF, m, 13'd0};
    end else if (e != 5'd0) begin
      res = {h[15], 8'(e) + 8'd112, m, 13'd0};
    end else if (m == 10'd0) begin
      res = {h[15], 31'd0};
    end else begin
      res = {h[15], 8'd113 - 8'(lz) - 8'd1, mm[9:0], 13'd0};
    end
    return res;
  endfunction

  function automatic logic is_nan32(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

endpackage

// ===== hw/rtl/mpea_align.sv =====
// Stage 1: operand widening, special-case detection and mantissa alignment.
module mpea_align (
  input  logic                  clk,
  input  logic [31:0]           a_bits,
  input  logic [31:0]           b_bits,
  input  mpea_pkg::combo_t      combo,
  input  logic                  en,
  output mpea_pkg::align_t      q_r
);
  import mpea_pkg::*;

  logic [31:0] wa, wb, big, lit;
  logic        swap;
  logic [7:0]  ea, eb, dexp;
  logic [26:0] ml, msr, sh;
  logic        sticky;
  align_t      q_nxt;

  // Widen the operands into binary32.
  always_comb begin
    case (combo)
      COMBO_F16, COMBO_F16_F16O, COMBO_F16_F32O: wa = f16_to_f32(a_bits[15:0]);
      COMBO_BF16, COMBO_BF_BFO, COMBO_BF_F32O:   wa = {a_bits[15:0], 16'd0};
      default:                                    wa = a_bits;
    endcase
    case (combo)
      COMBO_F16:  wb = f16_to_f32(b_bits[15:0]);
      COMBO_BF16: wb = {b_bits[15:0], 16'd0};
      default:    wb = b_bits;
    endcase
  end

  // Order by magnitude and shift the smaller mantissa with a sticky bit.
  always_comb begin
    swap = wb[30:0] > wa[30:0];
    big  = swap ? wb : wa;
    lit  = swap ? wa : wb;
    ea = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
    dexp = ea - eb;
    ml  = {(big[30:23] != 8'd0), big[22:0], 3'd0};
    msr = {(lit[30:23] != 8'd0), lit[22:0], 3'd0};
    if (dexp > 8'd26) begin
      sh = 27'd0;
      sticky = msr != 27'd0;
    end else begin
      sh = msr >> dexp;
      sticky = (msr & ((27'd1 << dexp) - 27'd1)) != 27'd0;
    end
    q_nxt.mant_s = {sh[26:1], sh[0] | sticky};
    q_nxt.mant_l = ml;
    q_nxt.exp_l  = ea;
    q_nxt.sign_l = big[31];
    q_nxt.sub    = wa[31] ^ wb[31];
    q_nxt.nan_res = is_nan32(wa) || is_nan32(wb);
    q_nxt.nan_val = is_nan32(wa) ? (wa | 32'h0040_0000) : (wb | 32'h0040_0000);
    q_nxt.inv = (wa[30:0] == 31'h7F80_0000) && (wb[30:0] == 31'h7F80_0000)
                && (wa[31] != wb[31]);
    case (combo)
      COMBO_F16, COMBO_F16_F16O: q_nxt.fmt = OUT_F16;
      COMBO_BF16, COMBO_BF_BFO:  q_nxt.fmt = OUT_BF16;
      default:                   q_nxt.fmt = OUT_F32;
    endcase
  end

  // Payload register, loaded when the stage advances.
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ===== hw/rtl/mpea_addnorm.sv =====
// Stage 2: mantissa add or subtract and normalization to a 28-bit sum.
module mpea_addnorm (
  input  logic             clk,
  input  logic             en,
  input  mpea_pkg::align_t d,
  output mpea_pkg::sum_t   q_r
);
  import mpea_pkg::*;

  logic [27:0] raw, nrm;
  logic [4:0]  lz;
  logic        found;
  logic [9:0]  e;
  sum_t        q_nxt;

  // Add, then find the leading one and normalize.
  always_comb begin
    if (d.sub) raw = {1'b0, d.mant_l} - {1'b0, d.mant_s};
    else       raw = {1'b0, d.mant_l} + {1'b0, d.mant_s};
    lz = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && raw[i]) begin
        found = 1'b1;
        lz = 5'(26 - i);
      end
    end
    e = {2'b00, d.exp_l};
    if (raw[27]) begin
      nrm = {1'b0, raw[27:2], raw[1] | raw[0]};
      e = e + 10'd1;
    end else if (!found || {5'd0, lz} >= e - 10'd1) begin
      // Result is subnormal or zero: shift only down to the minimum exponent.
      nrm = raw << (e - 10'd1);
      e = 10'd0;
    end else begin
      nrm = raw << lz;
      e = e - 10'(lz);
    end
    q_nxt.mant = nrm;
    q_nxt.exp  = e;
    q_nxt.sign = (raw == 28'd0) ? (d.sub ? 1'b0 : d.sign_l) : d.sign_l;
    q_nxt.fmt  = d.fmt;
    q_nxt.special = d.nan_res || d.inv || (d.exp_l == 8'hFF);
    if (d.nan_res)      q_nxt.special_val = d.nan_val;
    else if (d.inv)     q_nxt.special_val = QNAN32;
    else                q_nxt.special_val = {d.sign_l, 8'hFF, 23'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ===== hw/rtl/mpea_round.sv =====
// Stage 3: binary32 rounding and narrowing to the destination format.
module mpea_round (
  input  logic           clk,
  input  logic           en,
  input  mpea_pkg::sum_t d,
  output logic [31:0]    q_r
);
  import mpea_pkg::*;

  logic [24:0] mr;
  logic [9:0]  e;
  logic [31:0] s;
  logic [31:0] h;
  logic [7:0]  fe;
  logic [22:0] fm;
  logic signed [9:0] ex;
  logic [24:0] mant, rem, half, r;
  logic [4:0]  shift;
  logic [15:0] hres, bres;
  logic [31:0] q_nxt;

  // Round the binary32 sum to nearest even.
  always_comb begin
    mr = {1'b0, d.mant[26:3]};
    if (d.mant[2] && (d.mant[1] || d.mant[0] || d.mant[3])) mr = mr + 25'd1;
    e = d.exp;
    if (mr[24]) begin
      mr = mr >> 1;
      e = e + 10'd1;
    end else if (e == 10'd0 && mr[23]) begin
      e = 10'd1;
    end
    if (d.special)            s = d.special_val;
    else if (e >= 10'd255)    s = {d.sign, 8'hFF, 23'd0};
    else                      s = {d.sign, e[7:0], mr[22:0]};
  end

  // Narrow to half precision or bfloat16 and select the destination format.
  always_comb begin
    h = s;
    fe = h[30:23];
    fm = h[22:0];
    ex = $signed({2'b00, fe}) - 10'sd112;
    mant = {1'b0, 1'b1, fm} ;
    shift = 5'd13;
    r = 25'd0;
    rem = 25'd0;
    half = 25'd0;
    if (ex <= 10'sd0) begin
      shift = 5'(10'sd14 - ex);
      r = mant >> shift;
      rem = mant & ((25'd1 << shift) - 25'd1);
      half = 25'd1 << (shift - 5'd1);
    end else begin
      r = {10'd0, ex[4:0], fm[22:13]};
      rem = {12'd0, fm[12:0]};
      half = 25'h1000;
    end
    if (rem > half || (rem == half && r[0])) r = r + 25'd1;
    if (fe == 8'hFF)              hres = {h[31], (fm != 23'd0) ? 15'h7E00 : 15'h7C00};
    else if (ex >= 10'sd31)       hres = {h[31], 15'h7C00};
    else if (ex < -10'sd10)       hres = {h[31], 15'd0};
    else                          hres = {h[31], r[14:0]};
    if (is_nan32(s)) bres = s[31:16] | 16'h0040;
    else             bres = 16'((s + 32'h7FFF + {31'd0, s[16]}) >> 16);
    case (d.fmt)
      OUT_F16:  q_nxt = {16'd0, hres};
      OUT_BF16: q_nxt = {16'd0, bres};
      default:  q_nxt = s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ===== hw/rtl/mixed_precision_elementwise_add_unit.sv =====
// Top level of the mixed-precision elementwise adder.
// Usage:
//   The input stream carries one operand pair per word; in_tdata holds a_bits
//   in bits 31:0 and b_bits in bits 63:32. The output stream returns the sum
//   in out_tdata. cfg_we with cfg_wdata selects the type combination; write
//   it only while no word is in flight.
// Throughput: one word per cycle while out_tready is high. The unit is a
//   three-stage pipeline (align, add and normalize, round and narrow),
//   each stage with a valid bit.
// Reset: rst_n clears all valid bits and sets the type combination to
//   binary32 for both operands and the result.
// Stall: when out_tready is low, a stage holds its word only if the stage
//   after it is full; bubbles close up, so in_tready stays high while any
//   stage is empty. Nothing is dropped or repeated.
module mixed_precision_elementwise_add_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_bits [31:0], b_bits [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // sum_bits [31:0]
);
  import mpea_pkg::*;

  combo_t      combo_r;
  logic [2:0]  v_r;
  logic [2:0]  en;
  align_t      s1_q;
  sum_t        s2_q;

  // Per-stage advance with bubble collapsing.
  assign en[2]     = !v_r[2] || out_tready;
  assign en[1]     = !v_r[1] || en[2];
  assign en[0]     = !v_r[0] || en[1];
  assign in_tready = en[0];
  assign out_tvalid = v_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      combo_r <= COMBO_F32;
      v_r <= 3'd0;
    end else begin
      if (cfg_we) combo_r <= combo_t'(cfg_wdata);
      if (en[0]) v_r[0] <= in_tvalid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  mpea_align u_align (
    .clk(clk), .a_bits(in_tdata[31:0]), .b_bits(in_tdata[63:32]),
    .combo(combo_r), .en(en[0]), .q_r(s1_q)
  );

  mpea_addnorm u_add (.clk(clk), .en(en[1]), .d(s1_q), .q_r(s2_q));

  mpea_round u_round (.clk(clk), .en(en[2]), .d(s2_q), .q_r(out_tdata));

`ifndef SYNTH
  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  // Input is taken whenever the pipe has room.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_tready)
    else $error("ready low with empty stage");
  // A full pipe with a stalled sink refuses input.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_tready |-> !in_tready)
    else $error("word accepted into full pipe");
`endif
endmodule
